>>> rtl/mtep_pkg.sv
// Package for the track event parser: status codes, result kinds, phase and
// record types shared by the step logic, the output stage and the top level.
// No dependencies.
package mtep_pkg;

    localparam int VAL_W             = 28;
    localparam int VLQ_MAX_BYTES_DEF = 4;

    localparam logic [7:0] ST_CHAN_LO   = 8'h80;
    localparam logic [7:0] ST_CHAN_HI   = 8'hEF;
    localparam logic [7:0] ST_ONE_LO    = 8'hC0;
    localparam logic [7:0] ST_ONE_HI    = 8'hDF;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] META_EOT     = 8'h2F;

    typedef enum logic [2:0] {
        KIND_EVENT   = 3'd0,
        KIND_END     = 3'd1,
        KIND_UNKNOWN = 3'd2,
        KIND_TRUNC   = 3'd3,
        KIND_LONG    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        PH_DELTA    = 3'd0,
        PH_STATUS   = 3'd1,
        PH_DATA1    = 3'd2,
        PH_DATA2    = 3'd3,
        PH_METATYPE = 3'd4,
        PH_LENGTH   = 3'd5,
        PH_SKIP     = 3'd6
    } t_phase;

    // per-event parse state (VLQ byte count kept apart, its width is parameterised)
    typedef struct packed {
        t_phase             phase;
        logic [VAL_W-1:0]   delta;
        logic [7:0]         status;
        logic [7:0]         first;
        logic [7:0]         second;
        logic [VAL_W-1:0]   len;
        logic [VAL_W-1:0]   left;
        logic               halted;
    } t_parse_state;

    typedef struct packed {
        t_kind              kind;
        logic [VAL_W-1:0]   delta_ticks;
        logic [7:0]         status_value;
        logic [7:0]         first_data;
        logic [7:0]         second_data;
        logic [VAL_W-1:0]   payload_length;
    } t_result;

endpackage

>>> rtl/mtep_stream_if.sv
// Valid/ready channel interfaces for the track event parser: byte input and
// event result output. Depends on mtep_pkg.
interface mtep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mtep_event_if;
    import mtep_pkg::*;
    logic                   valid;
    logic                   ready;
    t_kind                  kind;
    logic [VAL_W-1:0]       delta_ticks;
    logic [7:0]             status_value;
    logic [7:0]             first_data;
    logic [7:0]             second_data;
    logic [VAL_W-1:0]       payload_length;

    modport source (output valid, output kind, output delta_ticks, output status_value,
                    output first_data, output second_data, output payload_length,
                    input ready);
    modport sink   (input valid, input kind, input delta_ticks, input status_value,
                    input first_data, input second_data, input payload_length,
                    output ready);
endinterface

>>> rtl/midi_track_event_parser_top.sv
// Track chunk event parser, top level: parse state registers, byte step logic
// and the result registers. Depends on mtep_pkg, mtep_stream_if, mtep_step,
// mtep_out_stage.
//
// Usage
//   i_bytes : track chunk bytes, one per transfer; last_byte marks the chunk's
//             final byte, after which the parser is back at an event boundary.
//   o_events: one transfer per complete event or per flagged condition (end of
//             track, unknown or running status, truncation, over-long VLQ).
//   Throughput: one byte per cycle if the skid is free. Each byte is one
//   pass through the step logic between the parse state and result registers.
//   Latency: a result is valid in the cycle after the transfer of the byte
//   that completes (or flags) the event, or once the result ahead of it is taken.
//   Stall: a result that waits untaken sends the next one to a skid register;
//   the byte channel drops ready (a registered signal) only while that skid
//   register is full. After a flag, bytes are swallowed without result until
//   last_byte.
//   Reset (synchronous, active low): parser idle awaiting a delta time, no
//   halt pending, no result held.
module midi_track_event_parser_top #(
    parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mtep_byte_if.sink    i_bytes,
    mtep_event_if.source o_events
);
    import mtep_pkg::*;

    localparam int CNT_W = $clog2(VLQ_MAX_BYTES + 1);

    t_parse_state     r_state;
    t_parse_state     n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             step_emit;
    t_result          step_result;
    logic             can_load;
    logic             take;

    // a byte transfer happens when a byte is valid and the skid register is free
    assign i_bytes.ready = can_load;
    assign take          = i_bytes.valid && can_load;

    mtep_step #(
        .VLQ_MAX_BYTES (VLQ_MAX_BYTES),
        .CNT_W         (CNT_W)
    ) u_step (
        .i_byte   (i_bytes.data_byte),
        .i_last   (i_bytes.last_byte),
        .i_state  (r_state),
        .i_cnt    (r_cnt),
        .o_state  (n_state),
        .o_cnt    (n_cnt),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    // parse state advances only on a byte transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= '0;
        end else if (take) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    mtep_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take && step_emit),
        .i_result   (step_result),
        .o_can_load (can_load),
        .o_evt      (o_events)
    );

endmodule

>>> rtl/mtep_step.sv
// Next-state logic for one track byte: VLQ decode, status classification,
// payload skip and error flags. Pure combinational. Depends on mtep_pkg.
module mtep_step #(
    parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF,
    parameter int CNT_W         = $clog2(VLQ_MAX_BYTES + 1)
) (
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    input  mtep_pkg::t_parse_state  i_state,
    input  logic [CNT_W-1:0]        i_cnt,
    output mtep_pkg::t_parse_state  o_state,
    output logic [CNT_W-1:0]        o_cnt,
    output logic                    o_emit,
    output mtep_pkg::t_result       o_result
);
    import mtep_pkg::*;

    logic [CNT_W-1:0] cnt_inc;
    logic             flag;
    t_kind            kind;
    t_parse_state     s;
    logic [CNT_W-1:0] c;

    assign cnt_inc = i_cnt + CNT_W'(1);

    always_comb begin
        s    = i_state;
        c    = i_cnt;
        flag = 1'b0;
        kind = KIND_EVENT;

        if (!i_state.halted) begin
            case (i_state.phase)
                PH_DELTA: begin
                    s.delta = {i_state.delta[VAL_W-8:0], i_byte[6:0]};
                    if (i_byte[7]) begin
                        c = cnt_inc;
                        if (cnt_inc >= CNT_W'(VLQ_MAX_BYTES)) begin
                            flag = 1'b1;
                            kind = KIND_LONG;
                        end
                    end else begin
                        c       = '0;
                        s.phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    s.status = i_byte;
                    if (i_byte >= ST_CHAN_LO && i_byte <= ST_CHAN_HI) begin
                        s.phase = PH_DATA1;
                    end else if (i_byte == ST_META) begin
                        s.phase = PH_METATYPE;
                    end else if (i_byte == ST_SYSEX || i_byte == ST_SYSEX_ESC) begin
                        c       = '0;
                        s.phase = PH_LENGTH;
                    end else begin
                        flag = 1'b1;
                        kind = KIND_UNKNOWN;
                    end
                end
                PH_DATA1: begin
                    s.first = i_byte;
                    if (i_state.status >= ST_ONE_LO && i_state.status <= ST_ONE_HI) begin
                        flag = 1'b1;
                    end else begin
                        s.phase = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    s.second = i_byte;
                    flag     = 1'b1;
                end
                PH_METATYPE: begin
                    s.first = i_byte;
                    if (i_byte == META_EOT) begin
                        flag = 1'b1;
                        kind = KIND_END;
                    end else begin
                        c       = '0;
                        s.phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    s.len = {i_state.len[VAL_W-8:0], i_byte[6:0]};
                    if (i_byte[7]) begin
                        c = cnt_inc;
                        if (cnt_inc >= CNT_W'(VLQ_MAX_BYTES)) begin
                            flag = 1'b1;
                            kind = KIND_LONG;
                        end
                    end else begin
                        c = '0;
                        if (s.len == '0) begin
                            flag = 1'b1;
                        end else begin
                            s.left  = s.len;
                            s.phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    s.left = i_state.left - VAL_W'(1);
                    if (s.left == '0) begin
                        flag = 1'b1;
                    end
                end
                default: begin
                    s        = '0;
                    c        = '0;
                end
            endcase
        end

        // result carries the fields as updated by this byte
        o_result.kind           = kind;
        o_result.delta_ticks    = s.delta;
        o_result.status_value   = s.status;
        o_result.first_data     = s.first;
        o_result.second_data    = s.second;
        o_result.payload_length = s.len;

        if (flag) begin
            if (kind == KIND_EVENT) begin
                s = '0;
                c = '0;
            end else begin
                s.halted = 1'b1;
            end
        end

        o_emit = flag;

        if (i_last) begin
            // chunk ends mid-event with nothing else reported
            if (!i_state.halted && !flag && !(s.phase == PH_DELTA && c == '0)) begin
                o_emit        = 1'b1;
                o_result.kind = KIND_TRUNC;
            end
            s = '0;
            c = '0;
        end

        o_state = s;
        o_cnt   = c;
    end

endmodule

>>> rtl/mtep_out_stage.sv
// Result registers on the output channel: an output register plus a skid
// register that catches one more event while the receiver stalls. Depends on mtep_pkg.
module mtep_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  mtep_pkg::t_result   i_result,
    output logic                o_can_load,
    mtep_event_if.source        o_evt
);
    import mtep_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    r_skid_valid;
    t_result r_skid;
    logic    main_free;

    // output register empties or is taken at this edge
    assign main_free  = !r_valid || o_evt.ready;
    assign o_can_load = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            r_valid      <= r_skid_valid || i_load;
            r_skid_valid <= 1'b0;
        end else if (i_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    // skid contents go out first; a new load only arrives while the skid is empty
    always_ff @(posedge i_clk) begin
        if (main_free) begin
            if (r_skid_valid) begin
                r_result <= r_skid;
            end else if (i_load) begin
                r_result <= i_result;
            end
        end else if (i_load) begin
            r_skid <= i_result;
        end
    end

    assign o_evt.valid          = r_valid;
    assign o_evt.kind           = r_result.kind;
    assign o_evt.delta_ticks    = r_result.delta_ticks;
    assign o_evt.status_value   = r_result.status_value;
    assign o_evt.first_data     = r_result.first_data;
    assign o_evt.second_data    = r_result.second_data;
    assign o_evt.payload_length = r_result.payload_length;

endmodule
